// ----- src/slcd_pkg.sv -----
package slcd_pkg;

	// stream payload widths
	localparam int COLOR_W     = 24;
	localparam int DELTA_W     = 17;
	localparam int S_TDATA_W   = 2 * COLOR_W;
	localparam int M_TDATA_W   = 24;
	localparam logic [DELTA_W-1:0] OUT_MAX = 17'h1FFFF;

	// default fixed-point fraction and queue size
	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH   = 4;

	// companding table, one entry per 8-bit channel code
	typedef logic [31:0] lut_t [256];

	// extra fraction bits dropped before the squares
	function automatic int work_shift(int frac);
		return (frac > 16) ? (frac - 16) : 0;
	endfunction

	// width of a rounded Lab difference magnitude
	function automatic int mag_w(int frac);
		return frac + 12 - work_shift(frac);
	endfunction

	// largest q30 fifth root, truncating q30 products
	function automatic longint unsigned root5(longint unsigned b);
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint unsigned p;
		lo = 64'd0;
		hi = 64'd1 << 30;
		while (lo < hi) begin
			mid = (lo + hi + 64'd1) >> 1;
			p = (mid * mid) >> 30;
			p = (p * mid) >> 30;
			p = (p * mid) >> 30;
			p = (p * mid) >> 30;
			if (p <= b)
				lo = mid;
			else
				hi = mid - 64'd1;
		end
		return lo;
	endfunction

	// inverse srgb companding for every channel code
	function automatic lut_t lin_lut(int frac);
		lut_t tab;
		longint unsigned v;
		longint unsigned b;
		longint unsigned r;
		longint unsigned b2;
		longint unsigned r2;
		longint unsigned p;
		longint unsigned sh;
		for (int i = 0; i < 256; i++) begin
			v = 64'(i);
			if (v * 64'd100000 > 64'd4045 * 64'd255) begin
				b  = (((64'd1000 * v + 64'd14025) << 30) + 64'd134512) / 64'd269025;
				r  = root5(b);
				b2 = (b * b) >> 30;
				r2 = (r * r) >> 30;
				p  = (b2 * r2) >> 30;
				sh = 64'(30 - frac);
				tab[i] = 32'((p + (64'd1 << (sh - 64'd1))) >> sh);
			end else begin
				tab[i] = 32'((((v * 64'd100) << frac) + 64'd164730) / 64'd329460);
			end
		end
		return tab;
	endfunction

endpackage

// ----- src/srgb_lab_color_distance_core.sv -----
// CIE76 colour difference of two packed sRGB colours under D65. One pair is taken per
// clock and one distance leaves per clock in steady state while the result is not held;
// each pair passes the input register, a four-entry queue and the back pipeline. The
// depth of that pipeline is set by the bit-serial cube root of the Lab function (two
// stages per result bit) and the one-bit-per-stage square root. A held result stalls the
// whole back pipeline; the queue and the input register keep the input open meanwhile
// for up to five more transfers.
module srgb_lab_color_distance_core import slcd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // color_a [23:0], color_b [47:24]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // delta_e [16:0], zero [23:17]
);

	localparam int LIN_SET_W = 6 * (FRAC_BITS + 1);

	logic                 push_valid;
	logic                 push_ready;
	logic [LIN_SET_W-1:0] push_data;
	logic                 head_valid;
	logic                 pop;
	logic [LIN_SET_W-1:0] head_data;
	logic [DELTA_W-1:0]   delta_e;

	slcd_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	slcd_queue #(
		.DATA_W(LIN_SET_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.head_valid(head_valid),
		.pop       (pop),
		.head_data (head_data)
	);

	slcd_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_data (head_data),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.delta_e   (delta_e)
	);

	assign m_tdata = {{(M_TDATA_W - DELTA_W){1'b0}}, delta_e};

endmodule

// ----- src/slcd_front.sv -----
module slcd_front import slcd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [S_TDATA_W-1:0]          s_tdata,
	output logic                          push_valid,
	input  logic                          push_ready,
	output logic [6*(FRAC_BITS+1)-1:0]    push_data
);

	localparam int   LIN_W   = FRAC_BITS + 1;
	localparam lut_t LIN_LUT = lin_lut(FRAC_BITS);

	logic                 held_q;
	logic [S_TDATA_W-1:0] colors_q;

	// one item held while the queue is full
	assign s_tready   = !held_q || push_ready;
	assign push_valid = held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
		end else if (s_tready) begin
			held_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			colors_q <= s_tdata;
		end
	end

	// linearise six channels: colour a r,g,b then colour b r,g,b
	for (genvar c = 0; c < 2; c++) begin : g_color
		for (genvar ch = 0; ch < 3; ch++) begin : g_chan
			assign push_data[(c*3+ch)*LIN_W +: LIN_W] =
				LIN_LUT[colors_q[c*COLOR_W + (2-ch)*8 +: 8]][LIN_W-1:0];
		end
	end

endmodule

// ----- src/slcd_queue.sv -----
module slcd_queue import slcd_pkg::*; #(
	parameter int DATA_W = 6 * (FRAC_BITS_DEF + 1),
	parameter int DEPTH  = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [DATA_W-1:0] push_data,
	output logic              head_valid,
	input  logic              pop,
	output logic [DATA_W-1:0] head_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- src/slcd_labf.sv -----
module slcd_labf import slcd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [FRAC_BITS+1:0] t,
	output logic [FRAC_BITS+1:0] f
);

	localparam int F_W = FRAC_BITS + 2;
	localparam int K   = FRAC_BITS + 2;
	localparam int LD  = 2 * K - 2;
	localparam longint unsigned TH  = ((64'd8856 << FRAC_BITS) + 64'd500000) / 64'd1000000;
	localparam longint unsigned C16 = ((64'd4 << FRAC_BITS) + 64'd29 / 2) / 64'd29;
	localparam int TH_W = (TH > 0) ? $clog2(TH + 1) : 1;
	localparam int N    = $clog2(64'd7787 * TH + 64'd501);
	localparam int S    = N + 10;
	localparam longint unsigned RECIP = ((64'd1 << S) + 64'd999) / 64'd1000;

	logic [30:0] tt0;
	logic [30:0] trial_a_s [K];
	logic [31:0] sq_a_s    [K];
	logic [30:0] c_a_s     [K];
	logic [30:0] tt_a_s    [K];
	logic [30:0] c_b_s     [K];
	logic [30:0] tt_b_s    [K];
	logic [F_W:0]   cube_rnd;
	logic [N-1:0]   n_s1;
	logic [2*N:0]   lin_prod;
	logic [F_W-1:0] lin_s2;
	logic [F_W-1:0] lin_d [LD];
	logic [2*K-1:0] sel_d;

	// argument in q30
	assign tt0 = 31'(t[FRAC_BITS:0]) << (30 - FRAC_BITS);

	// cube root, one result bit per two stages, msb first
	for (genvar j = 0; j < K; j++) begin : g_step
		logic [30:0] c_in;
		logic [30:0] tt_in;
		logic [30:0] trial;
		logic [61:0] sq_full;
		logic [62:0] cube_full;
		if (j == 0) begin : g_first
			assign c_in  = '0;
			assign tt_in = tt0;
		end else begin : g_next
			assign c_in  = c_b_s[j-1];
			assign tt_in = tt_b_s[j-1];
		end
		assign trial   = c_in | (31'd1 << (30 - j));
		assign sq_full = 62'(trial) * 62'(trial);
		always_ff @(posedge clk) begin
			if (en) begin
				trial_a_s[j] <= trial;
				sq_a_s[j]    <= sq_full[61:30];
				c_a_s[j]     <= c_in;
				tt_a_s[j]    <= tt_in;
			end
		end
		assign cube_full = 63'(sq_a_s[j]) * 63'(trial_a_s[j]);
		always_ff @(posedge clk) begin
			if (en) begin
				c_b_s[j]  <= (cube_full[62:30] <= {2'b00, tt_a_s[j]}) ? trial_a_s[j] : c_a_s[j];
				tt_b_s[j] <= tt_a_s[j];
			end
		end
	end

	assign cube_rnd = ((F_W+1)'(c_b_s[K-1][30 -: K]) + 1'b1) >> 1;

	// linear segment below the threshold, divide by 1000 through a reciprocal
	assign lin_prod = (2*N+1)'(n_s1) * (2*N+1)'(RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1   <= N'(64'd7787 * 64'(t[TH_W-1:0]) + 64'd500);
			lin_s2 <= F_W'(lin_prod >> S) + F_W'(C16);
			lin_d[0] <= lin_s2;
			for (int i = 1; i < LD; i++) begin
				lin_d[i] <= lin_d[i-1];
			end
			sel_d <= {sel_d[2*K-2:0], (t > F_W'(TH))};
			f     <= sel_d[2*K-1] ? F_W'(cube_rnd) : lin_d[LD-1];
		end
	end

endmodule

// ----- src/slcd_isqrt.sv -----
module slcd_isqrt import slcd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [2*mag_w(FRAC_BITS)+1:0]        n,
	output logic [mag_w(FRAC_BITS):0]            root
);

	localparam int S_W = 2 * mag_w(FRAC_BITS) + 2;
	localparam int SQ  = S_W / 2;

	logic [S_W-1:0] n_s   [SQ];
	logic [S_W-1:0] res_s [SQ];

	// restoring square root, one result bit per stage
	for (genvar j = 0; j < SQ; j++) begin : g_step
		localparam logic [S_W-1:0] BITV = S_W'(1) << (S_W - 2 - 2*j);
		logic [S_W-1:0] n_in;
		logic [S_W-1:0] res_in;
		logic [S_W-1:0] trial;
		if (j == 0) begin : g_first
			assign n_in   = n;
			assign res_in = '0;
		end else begin : g_next
			assign n_in   = n_s[j-1];
			assign res_in = res_s[j-1];
		end
		assign trial = res_in + BITV;
		always_ff @(posedge clk) begin
			if (en) begin
				if (n_in >= trial) begin
					n_s[j]   <= n_in - trial;
					res_s[j] <= (res_in >> 1) + BITV;
				end else begin
					n_s[j]   <= n_in;
					res_s[j] <= res_in >> 1;
				end
			end
		end
	end

	assign root = res_s[SQ-1][SQ-1:0];

endmodule

// ----- src/slcd_back.sv -----
module slcd_back import slcd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  logic [6*(FRAC_BITS+1)-1:0]    head_data,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [DELTA_W-1:0]            delta_e
);

	localparam int LIN_W = FRAC_BITS + 1;
	localparam int F_W   = FRAC_BITS + 2;
	localparam int P_W   = 2 * LIN_W;
	localparam int SUM_W = P_W + 2;
	localparam int D_W   = FRAC_BITS + 13;
	localparam int WS    = work_shift(FRAC_BITS);
	localparam int M_W   = mag_w(FRAC_BITS);
	localparam int S_W   = 2 * M_W + 2;
	localparam int SQ    = S_W / 2;
	localparam int Q_W   = SQ + 1;
	localparam int K     = FRAC_BITS + 2;
	localparam int LAT   = 3 + (2*K + 1) + 3 + SQ + 1;
	localparam int SH_O  = (FRAC_BITS - WS) - 8;
	localparam longint unsigned HALF_F  = 64'd1 << (FRAC_BITS - 1);
	localparam longint unsigned HALF_WS = (WS == 0) ? 64'd0 : (64'd1 << (WS - 1));
	localparam longint unsigned HALF_O  = (SH_O == 0) ? 64'd0 : (64'd1 << (SH_O - 1));

	// srgb to xyz rows, each divided by the d65 white
	localparam longint unsigned CXR = ((64'd41240 << FRAC_BITS) + 64'd95047 / 2) / 64'd95047;
	localparam longint unsigned CXG = ((64'd35760 << FRAC_BITS) + 64'd95047 / 2) / 64'd95047;
	localparam longint unsigned CXB = ((64'd18050 << FRAC_BITS) + 64'd95047 / 2) / 64'd95047;
	localparam longint unsigned CYR = ((64'd2126 << FRAC_BITS) + 64'd10000 / 2) / 64'd10000;
	localparam longint unsigned CYG = ((64'd7152 << FRAC_BITS) + 64'd10000 / 2) / 64'd10000;
	localparam longint unsigned CYB = ((64'd722 << FRAC_BITS) + 64'd10000 / 2) / 64'd10000;
	localparam longint unsigned CZR = ((64'd1930 << FRAC_BITS) + 64'd108883 / 2) / 64'd108883;
	localparam longint unsigned CZG = ((64'd11920 << FRAC_BITS) + 64'd108883 / 2) / 64'd108883;
	localparam longint unsigned CZB = ((64'd95050 << FRAC_BITS) + 64'd108883 / 2) / 64'd108883;
	localparam logic [LIN_W-1:0] CF [3][3] = '{
		'{LIN_W'(CXR), LIN_W'(CXG), LIN_W'(CXB)},
		'{LIN_W'(CYR), LIN_W'(CYG), LIN_W'(CYB)},
		'{LIN_W'(CZR), LIN_W'(CZG), LIN_W'(CZB)}
	};
	localparam logic signed [D_W-1:0] K116 = D_W'(116);
	localparam logic signed [D_W-1:0] K500 = D_W'(500);
	localparam logic signed [D_W-1:0] K200 = D_W'(200);

	logic                   adv;
	logic [LAT-1:0]         vld_q;
	logic [LIN_W-1:0]       lin_s1  [6];
	logic [P_W-1:0]         prod_s2 [2][3][3];
	logic [F_W-1:0]         t_s3    [2][3];
	logic [F_W-1:0]         f_lab   [2][3];
	logic signed [D_W-1:0]  ax, ay, az, bx, by, bz;
	logic signed [D_W-1:0]  p_dl, p_da, p_db;
	logic [D_W-2:0]         mg_dl, mg_da, mg_db;
	logic [M_W-1:0]         mag_s4  [3];
	logic [2*M_W-1:0]       sq_s5   [3];
	logic [S_W-1:0]         sum_s6;
	logic [SQ-1:0]          root;
	logic [Q_W-1:0]         q8;

	// whole pipeline moves while the output register can take a result
	assign adv      = !vld_q[LAT-1] || m_tready;
	assign pop      = adv && head_valid;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], head_valid};
		end
	end

	// linear rgb, matrix products, rounded xyz
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 6; i++) begin
				lin_s1[i] <= head_data[i*LIN_W +: LIN_W];
			end
			for (int c = 0; c < 2; c++) begin
				for (int row = 0; row < 3; row++) begin
					for (int ch = 0; ch < 3; ch++) begin
						prod_s2[c][row][ch] <= P_W'(CF[row][ch]) * P_W'(lin_s1[c*3+ch]);
					end
					t_s3[c][row] <= F_W'((SUM_W'(prod_s2[c][row][0]) + SUM_W'(prod_s2[c][row][1])
						+ SUM_W'(prod_s2[c][row][2]) + SUM_W'(HALF_F)) >> FRAC_BITS);
				end
			end
		end
	end

	// lab function per xyz component
	for (genvar c = 0; c < 2; c++) begin : g_color
		for (genvar row = 0; row < 3; row++) begin : g_row
			slcd_labf #(
				.FRAC_BITS(FRAC_BITS)
			) u_labf (
				.clk(clk),
				.en (adv),
				.t  (t_s3[c][row]),
				.f  (f_lab[c][row])
			);
		end
	end

	// scaled lab differences and their magnitudes
	always_comb begin
		ax = signed'(D_W'(f_lab[0][0]));
		ay = signed'(D_W'(f_lab[0][1]));
		az = signed'(D_W'(f_lab[0][2]));
		bx = signed'(D_W'(f_lab[1][0]));
		by = signed'(D_W'(f_lab[1][1]));
		bz = signed'(D_W'(f_lab[1][2]));
		p_dl = K116 * (ay - by);
		p_da = K500 * ((ax - ay) - (bx - by));
		p_db = K200 * ((ay - az) - (by - bz));
		mg_dl = p_dl[D_W-1] ? (D_W-1)'(-p_dl) : (D_W-1)'(p_dl);
		mg_da = p_da[D_W-1] ? (D_W-1)'(-p_da) : (D_W-1)'(p_da);
		mg_db = p_db[D_W-1] ? (D_W-1)'(-p_db) : (D_W-1)'(p_db);
	end

	// round to the working fraction, square, sum
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s4[0] <= M_W'((mg_dl + (D_W-1)'(HALF_WS)) >> WS);
			mag_s4[1] <= M_W'((mg_da + (D_W-1)'(HALF_WS)) >> WS);
			mag_s4[2] <= M_W'((mg_db + (D_W-1)'(HALF_WS)) >> WS);
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= (2*M_W)'(mag_s4[i]) * (2*M_W)'(mag_s4[i]);
			end
			sum_s6 <= S_W'(sq_s5[0]) + S_W'(sq_s5[1]) + S_W'(sq_s5[2]);
		end
	end

	slcd_isqrt #(
		.FRAC_BITS(FRAC_BITS)
	) u_isqrt (
		.clk (clk),
		.en  (adv),
		.n   (sum_s6),
		.root(root)
	);

	// round the root to q8 and saturate
	assign q8 = (Q_W'(root) + Q_W'(HALF_O)) >> SH_O;

	always_ff @(posedge clk) begin
		if (adv) begin
			delta_e <= (q8 > Q_W'(OUT_MAX)) ? OUT_MAX : DELTA_W'(q8);
		end
	end

endmodule

// ----- src/slcd_checker.sv -----
module slcd_checker import slcd_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// nothing leaves straight out of reset
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result offered after reset");

	// input closes only after a transfer filled the front register
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid && s_tready))
		else $error("input closed without a transfer");

	// padding above the distance is zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[M_TDATA_W-1:DELTA_W] == '0))
		else $error("nonzero padding in result");

endmodule

bind srgb_lab_color_distance_core slcd_checker u_checker (.*);
